// File: rtl/hsps_pkg.sv
// ----------------------------------------------------------------------------
// hsps_pkg: shared types and constants of the slot producer selector
// Holds the field widths, the hash multiplier, the sequencer states, the
// result codes and the small helper functions of the selector.
// ----------------------------------------------------------------------------
`default_nettype none

package hsps_pkg;

   localparam int COUNT_W = 10;
   localparam int ID_W    = 32;
   localparam int OFFSET_W = 32;
   localparam int TIME_W  = 32;
   localparam int KEY_W   = 64;
   localparam int HALF_W  = 32;

   // xorshift* multiplier and its two 32-bit halves
   localparam logic [KEY_W-1:0]  HASH_MUL    = 64'h2545_F491_4F6C_DD1D;
   localparam logic [HALF_W-1:0] HASH_MUL_LO = HASH_MUL[31:0];
   localparam logic [HALF_W-1:0] HASH_MUL_HI = HASH_MUL[63:32];

   typedef enum logic [1:0] {
      OUT_HASH   = 2'd0,
      OUT_NEWEST = 2'd1,
      OUT_SOLE   = 2'd2,
      OUT_NONE   = 2'd3
   } outcome_type;

   typedef enum logic [1:0] {
      MAC_IDLE,
      MAC_LOAD,
      MAC_ADD_HI
   } mac_op_type;

   // one command to the shared multiply-accumulate unit
   typedef struct packed {
      mac_op_type        op;
      logic [HALF_W-1:0] a;
      logic [HALF_W-1:0] b;
      logic [HALF_W-1:0] hi;
   } mac_cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV,
      ST_CUT,
      ST_LIMIT,
      ST_ELIG,
      ST_HASH_A,
      ST_HASH_B,
      ST_HASH_W,
      ST_MIX,
      ST_MUL_A,
      ST_MUL_B,
      ST_MUL_C,
      ST_MUL_W,
      ST_CMP,
      ST_DONE
   } state_type;

   // a count of zero acts as one
   function automatic logic [COUNT_W-1:0] count_eff(input logic [COUNT_W-1:0] n);
      return (n == '0) ? COUNT_W'(1) : n;
   endfunction

   // round separation: 1 for 2 or 3, 2 for 4, n/2+1 otherwise
   function automatic logic [COUNT_W-1:0] sep_of(input logic [COUNT_W-1:0] n);
      logic [COUNT_W-1:0] s;
      if (n == COUNT_W'(2) || n == COUNT_W'(3)) begin
         s = COUNT_W'(1);
      end else if (n == COUNT_W'(4)) begin
         s = COUNT_W'(2);
      end else begin
         s = (n >> 1) + COUNT_W'(1);
      end
      return s;
   endfunction

   // xorshift mixing between the two multiplies
   function automatic logic [KEY_W-1:0] xs_mix(input logic [KEY_W-1:0] k);
      logic [KEY_W-1:0] m;
      m = k ^ (k >> 12);
      m = m ^ (m << 25);
      m = m ^ (m >> 27);
      return m;
   endfunction

endpackage

`default_nettype wire

// File: rtl/hsps_chan_if.sv
// ----------------------------------------------------------------------------
// hsps_chan_if: request and response channels of the slot producer selector
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface hsps_req_if
   import hsps_pkg::*;
#(
   parameter int SLOT_BITS = 40
);
   logic                 valid;
   logic                 ready;
   logic [ID_W-1:0]      candidate_id;
   logic [SLOT_BITS-1:0] last_filled_slot;
   logic [SLOT_BITS-1:0] base_slot;
   logic [OFFSET_W-1:0]  slot_offset;
   logic [TIME_W-1:0]    slot_time;
   logic                 last_candidate;

   modport source (
      output valid, candidate_id, last_filled_slot, base_slot, slot_offset,
             slot_time, last_candidate,
      input  ready
   );
   modport sink (
      input  valid, candidate_id, last_filled_slot, base_slot, slot_offset,
             slot_time, last_candidate,
      output ready
   );
endinterface

interface hsps_rsp_if
   import hsps_pkg::*;
();
   logic            valid;
   logic            ready;
   logic [ID_W-1:0] chosen_id;
   outcome_type     outcome;

   modport source (
      output valid, chosen_id, outcome,
      input  ready
   );
   modport sink (
      input  valid, chosen_id, outcome,
      output ready
   );
endinterface

`default_nettype wire

// File: rtl/hashed_slot_producer_selector.sv
// ----------------------------------------------------------------------------
// hashed_slot_producer_selector: picks the producer of a future slot
// Reads a candidate list one request at a time and answers on the request
// marked as the last candidate with the chosen id and how it was chosen.
// ----------------------------------------------------------------------------
// The block takes one request at a time and is not ready while it works on
// it. A request that opens a query runs a bit-serial remainder of the query
// slot by the candidate count before the normal work. A candidate at or past
// the cutoff then skips the hash; an eligible candidate goes through the one
// 32x32 multiply-accumulate unit that builds both 64-bit xorshift* products
// from partial products. A response sits in an output register; the closing
// request waits only if that register is still full.
`default_nettype none

module hashed_slot_producer_selector
   import hsps_pkg::*;
#(
   parameter int SLOT_BITS = 40
)(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_wr_en,
   input  wire logic [COUNT_W-1:0] csr_wr_data,
   hsps_req_if.sink                req_chan,
   hsps_rsp_if.source              rsp_chan
);

   state_type            state_ff, state_in;
   logic [COUNT_W-1:0]   active_count_ff;
   logic                 query_open_ff, query_open_in;

   logic [ID_W-1:0]      id_ff, id_in;
   logic [SLOT_BITS-1:0] last_ff, last_in;
   logic [SLOT_BITS-1:0] q_ff, q_in;
   logic                 offset_zero_ff, offset_zero_in;
   logic [TIME_W-1:0]    time_ff, time_in;
   logic                 fin_ff, fin_in;

   logic [ID_W-1:0]      first_ff, first_in;
   logic                 have_best_ff, have_best_in;
   logic [KEY_W-1:0]     best_key_ff, best_key_in;
   logic [ID_W-1:0]      best_id_ff, best_id_in;
   logic                 have_newest_ff, have_newest_in;
   logic [ID_W-1:0]      newest_id_ff, newest_id_in;

   logic [SLOT_BITS-1:0] start_ff, start_in;
   logic [SLOT_BITS-1:0] back_ff, back_in;
   logic [SLOT_BITS-1:0] cutoff_ff, cutoff_in;
   logic [SLOT_BITS-1:0] low_slot;
   logic [KEY_W-1:0]     key_ff, key_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]      rsp_id_ff, rsp_id_in;
   outcome_type          rsp_outcome_ff, rsp_outcome_in;

   logic [COUNT_W-1:0]   n_eff;
   logic [SLOT_BITS-1:0] sep_ext;
   logic                 accept;
   logic                 rem_start;
   logic [COUNT_W-1:0]   rem_value;
   logic                 rem_done;
   logic [SLOT_BITS-1:0] req_q;
   mac_cmd_type          mac_cmd;
   logic [KEY_W-1:0]     mac_acc;

   assign n_eff   = count_eff(active_count_ff);
   assign sep_ext = SLOT_BITS'(sep_of(n_eff));
   assign req_q   = req_chan.base_slot + SLOT_BITS'(req_chan.slot_offset);
   assign low_slot = (start_ff < back_ff) ? start_ff : back_ff;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;

   // shared units
   hsps_rem #(
      .SLOT_BITS (SLOT_BITS)
   ) u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (rem_start),
      .dividend (req_q),
      .divisor  (n_eff),
      .rem      (rem_value),
      .done     (rem_done)
   );

   hsps_mac u_mac (
      .clock (clock),
      .reset (reset),
      .cmd   (mac_cmd),
      .acc   (mac_acc)
   );

   // sequencer: next state, unit commands and register updates
   always_comb begin
      state_in       = state_ff;
      query_open_in  = query_open_ff;
      id_in          = id_ff;
      last_in        = last_ff;
      q_in           = q_ff;
      offset_zero_in = offset_zero_ff;
      time_in        = time_ff;
      fin_in         = fin_ff;
      first_in       = first_ff;
      have_best_in   = have_best_ff;
      best_key_in    = best_key_ff;
      best_id_in     = best_id_ff;
      have_newest_in = have_newest_ff;
      newest_id_in   = newest_id_ff;
      start_in       = start_ff;
      back_in        = back_ff;
      cutoff_in      = cutoff_ff;
      key_in         = key_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_id_in      = rsp_id_ff;
      rsp_outcome_in = rsp_outcome_ff;
      rem_start      = 1'b0;
      mac_cmd        = '{op: MAC_IDLE, a: '0, b: '0, hi: '0};

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               id_in          = req_chan.candidate_id;
               last_in        = req_chan.last_filled_slot;
               q_in           = req_q;
               offset_zero_in = (req_chan.slot_offset == '0);
               time_in        = req_chan.slot_time;
               fin_in         = req_chan.last_candidate;
               if (!query_open_ff) begin
                  // open a query and start the round remainder
                  query_open_in  = 1'b1;
                  first_in       = req_chan.candidate_id;
                  have_best_in   = 1'b0;
                  best_key_in    = '0;
                  best_id_in     = '0;
                  have_newest_in = 1'b0;
                  newest_id_in   = '0;
                  rem_start      = 1'b1;
                  state_in       = ST_DIV;
               end else begin
                  state_in = ST_ELIG;
               end
            end
         end
         ST_DIV: begin
            if (rem_done) begin
               state_in = ST_CUT;
            end
         end
         ST_CUT: begin
            // round start and separation limit, clamped at zero
            start_in = q_ff - SLOT_BITS'(rem_value);
            back_in  = (q_ff >= sep_ext) ? q_ff - sep_ext : '0;
            state_in = ST_LIMIT;
         end
         ST_LIMIT: begin
            cutoff_in = (low_slot == '0) ? SLOT_BITS'(1) : low_slot;
            state_in  = ST_ELIG;
         end
         ST_ELIG: begin
            // newest producer check on an offset of zero
            if (offset_zero_ff && !have_newest_ff && last_ff >= q_ff) begin
               have_newest_in = 1'b1;
               newest_id_in   = id_ff;
            end
            state_in = (last_ff < cutoff_ff) ? ST_HASH_A : ST_DONE;
         end
         ST_HASH_A: begin
            mac_cmd  = '{op: MAC_LOAD, a: id_ff, b: HASH_MUL_LO, hi: time_ff};
            state_in = ST_HASH_B;
         end
         ST_HASH_B: begin
            mac_cmd  = '{op: MAC_ADD_HI, a: id_ff, b: HASH_MUL_HI, hi: '0};
            state_in = ST_HASH_W;
         end
         ST_HASH_W: begin
            state_in = ST_MIX;
         end
         ST_MIX: begin
            key_in   = xs_mix(mac_acc);
            state_in = ST_MUL_A;
         end
         ST_MUL_A: begin
            mac_cmd  = '{op: MAC_LOAD, a: key_ff[HALF_W-1:0], b: HASH_MUL_LO, hi: '0};
            state_in = ST_MUL_B;
         end
         ST_MUL_B: begin
            mac_cmd  = '{op: MAC_ADD_HI, a: key_ff[HALF_W-1:0], b: HASH_MUL_HI, hi: '0};
            state_in = ST_MUL_C;
         end
         ST_MUL_C: begin
            mac_cmd  = '{op: MAC_ADD_HI, a: key_ff[KEY_W-1:HALF_W], b: HASH_MUL_LO,
                         hi: '0};
            state_in = ST_MUL_W;
         end
         ST_MUL_W: begin
            state_in = ST_CMP;
         end
         ST_CMP: begin
            // keep the largest key, later candidate wins a tie
            if (!have_best_ff || mac_acc >= best_key_ff) begin
               have_best_in = 1'b1;
               best_key_in  = mac_acc;
               best_id_in   = id_ff;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!fin_ff) begin
               state_in = ST_IDLE;
            end else if (!rsp_valid_ff || rsp_chan.ready) begin
               // close the query and load the response
               query_open_in = 1'b0;
               rsp_valid_in  = 1'b1;
               if (n_eff == COUNT_W'(1)) begin
                  rsp_id_in      = first_ff;
                  rsp_outcome_in = OUT_SOLE;
               end else if (have_newest_ff) begin
                  rsp_id_in      = newest_id_ff;
                  rsp_outcome_in = OUT_NEWEST;
               end else if (have_best_ff) begin
                  rsp_id_in      = best_id_ff;
                  rsp_outcome_in = OUT_HASH;
               end else begin
                  rsp_id_in      = '0;
                  rsp_outcome_in = OUT_NONE;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         active_count_ff <= COUNT_W'(1);
         query_open_ff   <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         have_best_ff    <= 1'b0;
         have_newest_ff  <= 1'b0;
         cutoff_ff       <= '0;
      end else begin
         state_ff      <= state_in;
         query_open_ff <= query_open_in;
         rsp_valid_ff  <= rsp_valid_in;
         have_best_ff  <= have_best_in;
         have_newest_ff <= have_newest_in;
         cutoff_ff     <= cutoff_in;
         if (csr_wr_en) begin
            active_count_ff <= csr_wr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      id_ff          <= id_in;
      last_ff        <= last_in;
      q_ff           <= q_in;
      offset_zero_ff <= offset_zero_in;
      time_ff        <= time_in;
      fin_ff         <= fin_in;
      first_ff       <= first_in;
      best_key_ff    <= best_key_in;
      best_id_ff     <= best_id_in;
      newest_id_ff   <= newest_id_in;
      start_ff       <= start_in;
      back_ff        <= back_in;
      key_ff         <= key_in;
      rsp_id_ff      <= rsp_id_in;
      rsp_outcome_ff <= rsp_outcome_in;
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.chosen_id = rsp_id_ff;
   assign rsp_chan.outcome   = rsp_outcome_ff;

`ifndef SYNTHESIS
   // an opening request always goes through the remainder unit
   a_open_divides: assert property (@(posedge clock) disable iff (reset)
      (accept && !query_open_ff) |=> (state_ff == ST_DIV))
      else $error("opening request did not start the remainder");

   // the cutoff is set and nonzero whenever a candidate is checked
   a_cutoff_set: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ELIG) |-> (cutoff_ff != '0))
      else $error("eligibility checked against an unset cutoff");

   // a response with no eligible candidate carries id zero
   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.outcome == OUT_NONE) |-> (rsp_chan.chosen_id == '0))
      else $error("empty outcome with nonzero id");
`endif

endmodule

`default_nettype wire

// File: rtl/hsps_mac.sv
// ----------------------------------------------------------------------------
// hsps_mac: shared 32x32 multiply-accumulate unit
// One product per cycle is registered, then loaded into a 64-bit accumulator
// or added into its upper half on the following cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module hsps_mac
   import hsps_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire mac_cmd_type       cmd,
   output logic [KEY_W-1:0]       acc
);

   mac_op_type        op_ff;
   logic [KEY_W-1:0]  prod_ff;
   logic [HALF_W-1:0] hi_ff;
   logic [KEY_W-1:0]  acc_ff;
   logic [KEY_W-1:0]  acc_in;

   // stage the operation along with its product
   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff <= MAC_IDLE;
      end else begin
         op_ff <= cmd.op;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= KEY_W'(cmd.a) * KEY_W'(cmd.b);
      hi_ff   <= cmd.hi;
      acc_ff  <= acc_in;
   end

   // load or accumulate the registered product
   always_comb begin
      case (op_ff)
         MAC_LOAD:   acc_in = prod_ff + {hi_ff, {HALF_W{1'b0}}};
         MAC_ADD_HI: acc_in = {acc_ff[KEY_W-1:HALF_W] + prod_ff[HALF_W-1:0],
                               acc_ff[HALF_W-1:0]};
         default:    acc_in = acc_ff;
      endcase
   end

   assign acc = acc_ff;

endmodule

`default_nettype wire

// File: rtl/hsps_rem.sv
// ----------------------------------------------------------------------------
// hsps_rem: bit-serial remainder of the query slot by the candidate count
// Restoring division over all SLOT_BITS dividend bits, one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module hsps_rem
   import hsps_pkg::*;
#(
   parameter int SLOT_BITS = 40
)(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [SLOT_BITS-1:0] dividend,
   input  wire logic [COUNT_W-1:0]   divisor,
   output logic [COUNT_W-1:0]        rem,
   output logic                      done
);

   localparam int CNT_W = $clog2(SLOT_BITS);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [SLOT_BITS-1:0] quo_ff, quo_in;
   logic [COUNT_W-1:0]   rem_ff, rem_in;
   logic [COUNT_W:0]     rem_shift;
   logic [COUNT_W:0]     rem_next;

   // shift in the next dividend bit and subtract the divisor when it fits
   assign rem_shift = {rem_ff, quo_ff[SLOT_BITS-1]};
   assign rem_next  = (rem_shift >= {1'b0, divisor}) ? rem_shift - {1'b0, divisor}
                                                      : rem_shift;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(SLOT_BITS - 1);
         quo_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         quo_in = quo_ff << 1;
         rem_in = rem_next[COUNT_W-1:0];
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign rem  = rem_ff;
   assign done = done_ff;

endmodule

`default_nettype wire
